@@ rtl/ihs_pkg.sv @@
// Shared constants, codes and types of the item support histogram.
package ihs_pkg;

   // default sizing
   localparam int NUM_BINS_DEFAULT   = 4096;
   localparam int COUNT_BITS_DEFAULT = 32;

   // request kinds, carried in req_tuser
   localparam logic [1:0] REQ_TEXT = 2'd0;
   localparam logic [1:0] REQ_END  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // result kinds, carried in rsp_tuser
   localparam logic RSP_SUMMARY = 1'b0;
   localparam logic RSP_BIN     = 1'b1;

   // characters
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam int         DIGIT_BASE = 10;

   // field widths
   localparam int KIND_BITS     = 2;
   localparam int BYTE_BITS     = 8;
   localparam int INDEX_BITS    = 12;
   localparam int OUT_COUNT_BITS = 32;
   localparam int USED_BITS     = 13;

   // stream widths
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 80;

   // rsp_tdata field positions
   localparam int RSP_TXN_LSB   = 0;
   localparam int RSP_USED_LSB  = 32;
   localparam int RSP_VALUE_LSB = 45;
   localparam int RSP_RANGE_BIT = 77;
   localparam int RSP_SAT_BIT   = 78;

   // parser status towards the top level
   typedef struct packed {
      logic inc_req;    // a finished item hits a bin this transfer
      logic any_item;   // some in-range item has been seen
      logic range_err;  // sticky: an item was too large
      logic line_sat;   // sticky: line count saturated
   } parse_status_type;

   // histogram update status
   typedef struct packed {
      logic clear_busy; // clearing pass after reset in progress
      logic sat_hit;    // bin being updated is already at its maximum
   } update_status_type;

endpackage

@@ rtl/ihs_bin_ram.sv @@
// Single-port-write, single-port-read histogram memory with registered read data.
module ihs_bin_ram #(
   parameter int DEPTH = ihs_pkg::NUM_BINS_DEFAULT,
   parameter int WIDTH = ihs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] bins_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bins_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bins_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ihs_text_parse.sv @@
// Text parser: number accumulation, line count, highest item and sticky flags.
module ihs_text_parse #(
   parameter int NUM_BINS   = ihs_pkg::NUM_BINS_DEFAULT,
   parameter int COUNT_BITS = ihs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [ihs_pkg::KIND_BITS-1:0] kind,
   input  logic [ihs_pkg::BYTE_BITS-1:0] text_byte,
   output logic [$clog2(NUM_BINS)-1:0]   inc_addr,
   output logic [$clog2(NUM_BINS)-1:0]   highest_item,
   output logic [COUNT_BITS-1:0]         line_count,
   output ihs_pkg::parse_status_type     status
);

   localparam int IDX_BITS = $clog2(NUM_BINS);
   localparam int ACC_BITS = $clog2(NUM_BINS + 1);
   localparam int MUL_BITS = ACC_BITS + 4;

   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic                  digit_seen_ff, digit_seen_in;
   logic [COUNT_BITS-1:0] line_ff, line_in;
   logic [IDX_BITS-1:0]   highest_ff, highest_in;
   logic                  any_ff, any_in;
   logic                  range_ff, range_in;
   logic                  line_sat_ff, line_sat_in;

   logic                  is_digit;
   logic                  finish;
   logic                  item_done;
   logic                  too_big;
   logic                  inc_req;
   logic                  newline;
   logic [3:0]            digit;
   logic [MUL_BITS-1:0]   acc_mul;

   always_comb begin
      is_digit  = (text_byte >= ihs_pkg::CH_ZERO) && (text_byte <= ihs_pkg::CH_NINE);
      finish    = take && (((kind == ihs_pkg::REQ_TEXT) && !is_digit) ||
                           (kind == ihs_pkg::REQ_END));
      item_done = finish && digit_seen_ff;
      too_big   = acc_ff >= ACC_BITS'(NUM_BINS);
      inc_req   = item_done && !too_big;
      newline   = take && (kind == ihs_pkg::REQ_TEXT) && (text_byte == ihs_pkg::CH_NEWLINE);
      digit     = 4'(text_byte - ihs_pkg::CH_ZERO);
      // times ten as two shifts
      acc_mul   = (MUL_BITS'(acc_ff) << 3) + (MUL_BITS'(acc_ff) << 1) + MUL_BITS'(digit);

      acc_in        = acc_ff;
      digit_seen_in = digit_seen_ff;
      line_in       = line_ff;
      line_sat_in   = line_sat_ff;
      highest_in    = highest_ff;
      any_in        = any_ff;
      range_in      = range_ff;

      if (take && (kind == ihs_pkg::REQ_TEXT) && is_digit) begin
         // clamp once the number reaches the table size
         if (acc_mul > MUL_BITS'(NUM_BINS)) begin
            acc_in = ACC_BITS'(NUM_BINS);
         end else begin
            acc_in = ACC_BITS'(acc_mul);
         end
         digit_seen_in = 1'b1;
      end
      if (finish) begin
         acc_in        = '0;
         digit_seen_in = 1'b0;
      end
      if (item_done && too_big) begin
         range_in = 1'b1;
      end
      if (inc_req) begin
         if (!any_ff || (acc_ff[IDX_BITS-1:0] > highest_ff)) begin
            highest_in = acc_ff[IDX_BITS-1:0];
         end
         any_in = 1'b1;
      end
      if (newline) begin
         if (line_ff == {COUNT_BITS{1'b1}}) begin
            line_sat_in = 1'b1;
         end else begin
            line_in = line_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         digit_seen_ff <= 1'b0;
         line_ff       <= '0;
         line_sat_ff   <= 1'b0;
         highest_ff    <= '0;
         any_ff        <= 1'b0;
         range_ff      <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         digit_seen_ff <= digit_seen_in;
         line_ff       <= line_in;
         line_sat_ff   <= line_sat_in;
         highest_ff    <= highest_in;
         any_ff        <= any_in;
         range_ff      <= range_in;
      end
   end

   assign inc_addr         = acc_ff[IDX_BITS-1:0];
   assign highest_item     = highest_ff;
   assign line_count       = line_ff;
   assign status.inc_req   = inc_req;
   assign status.any_item  = any_ff;
   assign status.range_err = range_ff;
   assign status.line_sat  = line_sat_ff;

endmodule

@@ rtl/ihs_bin_update.sv @@
// Histogram read-modify-write with clearing pass and write forwarding.
module ihs_bin_update #(
   parameter int NUM_BINS   = ihs_pkg::NUM_BINS_DEFAULT,
   parameter int COUNT_BITS = ihs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [$clog2(NUM_BINS)-1:0] rd_addr,
   input  logic                        commit_inc,
   output logic [COUNT_BITS-1:0]       cur_value,
   output ihs_pkg::update_status_type  status
);

   localparam int IDX_BITS = $clog2(NUM_BINS);

   logic                  clear_busy_ff;
   logic [IDX_BITS-1:0]   clear_addr_ff;
   logic [IDX_BITS-1:0]   addr_ff;
   logic                  last_wr_valid_ff;
   logic [IDX_BITS-1:0]   last_wr_addr_ff;
   logic [COUNT_BITS-1:0] last_wr_data_ff;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS-1:0] ram_data;
   logic                  sat_hit;
   logic [COUNT_BITS-1:0] inc_value;

   ihs_bin_ram #(
      .DEPTH (NUM_BINS),
      .WIDTH (COUNT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   always_comb begin
      // the latest write always matches the memory, so forwarding it is safe
      if (last_wr_valid_ff && (last_wr_addr_ff == addr_ff)) begin
         cur_value = last_wr_data_ff;
      end else begin
         cur_value = ram_data;
      end
      sat_hit   = cur_value == {COUNT_BITS{1'b1}};
      inc_value = sat_hit ? cur_value : cur_value + 1'b1;

      if (clear_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = commit_inc;
         wr_addr = addr_ff;
         wr_data = inc_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff    <= 1'b1;
         clear_addr_ff    <= '0;
         last_wr_valid_ff <= 1'b0;
      end else begin
         if (clear_busy_ff) begin
            if (clear_addr_ff == IDX_BITS'(NUM_BINS - 1)) begin
               clear_busy_ff <= 1'b0;
            end else begin
               clear_addr_ff <= clear_addr_ff + 1'b1;
            end
         end
         if (!clear_busy_ff && commit_inc) begin
            last_wr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_ff <= rd_addr;
      end
      if (!clear_busy_ff && commit_inc) begin
         last_wr_addr_ff <= addr_ff;
         last_wr_data_ff <= inc_value;
      end
   end

   assign status.clear_busy = clear_busy_ff;
   assign status.sat_hit    = sat_hit;

endmodule

@@ rtl/item_support_histogram_unit.sv @@
// A result passes the s1 stage and then the result register before it shows on rsp_tvalid.
// Throughput: one request per cycle while the result side keeps up; a held result
// stalls req_tready only when a further result reaches the bin memory read stage.
// Bin updates run a two-stage read-modify-write on one memory, forwarded from the last write.
// Reset: synchronous; a clearing pass zeroes every bin, req_tready low meanwhile.
// Top level of the item support histogram.
module item_support_histogram_unit #(
   parameter int NUM_BINS   = ihs_pkg::NUM_BINS_DEFAULT,
   parameter int COUNT_BITS = ihs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // text_byte [7:0], bin_index [19:8], zero [23:20]
   input  logic [ihs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // kind [1:0]
   input  logic [ihs_pkg::KIND_BITS-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // transaction_count [31:0], bins_used [44:32], bin_value [76:45],
   // item_out_of_range [77], count_saturated [78], zero [79]
   output logic [ihs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // result_kind [0]
   output logic                              rsp_tuser
);

   localparam int IDX_BITS = $clog2(NUM_BINS);
   localparam int RD_BITS  = ((IDX_BITS > ihs_pkg::INDEX_BITS) ?
                              IDX_BITS : ihs_pkg::INDEX_BITS) + 1;

   typedef struct packed {
      logic valid;
      logic inc;
      logic rsp;
      logic rsp_kind;
      logic zero;
   } stage_type;

   stage_type s1_ff, s1_in;

   logic                               rsp_valid_ff;
   logic [ihs_pkg::RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                               rsp_kind_ff;
   logic                               bin_sat_ff;

   logic [ihs_pkg::BYTE_BITS-1:0]      text_byte;
   logic [ihs_pkg::INDEX_BITS-1:0]     bin_index;
   logic [RD_BITS-1:0]                 idx_ext;
   logic                               idx_in_range;
   logic                               take;
   logic                               slot_free;
   logic                               s1_advance;
   logic                               rd_en;
   logic [IDX_BITS-1:0]                rd_addr;

   logic [IDX_BITS-1:0]                inc_addr;
   logic [IDX_BITS-1:0]                highest_item;
   logic [IDX_BITS:0]                  highest_p1;
   logic [COUNT_BITS-1:0]              line_count;
   logic [COUNT_BITS-1:0]              cur_value;
   ihs_pkg::parse_status_type          p_status;
   ihs_pkg::update_status_type         u_status;

   logic                               sat_now;
   logic [ihs_pkg::OUT_COUNT_BITS-1:0] txn_out;
   logic [ihs_pkg::USED_BITS-1:0]      used_out;
   logic [ihs_pkg::OUT_COUNT_BITS-1:0] value_out;

   assign text_byte    = req_tdata[7:0];
   assign bin_index    = req_tdata[19:8];
   assign idx_ext      = RD_BITS'(bin_index);
   assign idx_in_range = idx_ext < RD_BITS'(NUM_BINS);

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_ff.valid && (!s1_ff.rsp || slot_free);
   assign req_tready = !u_status.clear_busy && (!s1_ff.valid || s1_advance);
   assign take       = req_tvalid && req_tready;

   ihs_text_parse #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .kind         (req_tuser),
      .text_byte    (text_byte),
      .inc_addr     (inc_addr),
      .highest_item (highest_item),
      .line_count   (line_count),
      .status       (p_status)
   );

   assign rd_en   = take && (p_status.inc_req ||
                             ((req_tuser == ihs_pkg::REQ_READ) && idx_in_range));
   assign rd_addr = p_status.inc_req ? inc_addr : idx_ext[IDX_BITS-1:0];

   ihs_bin_update #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .commit_inc (s1_advance && s1_ff.inc),
      .cur_value  (cur_value),
      .status     (u_status)
   );

   always_comb begin
      s1_in = s1_ff;
      if (s1_advance) begin
         s1_in.valid = 1'b0;
      end
      if (take) begin
         s1_in.inc      = p_status.inc_req;
         s1_in.rsp      = (req_tuser == ihs_pkg::REQ_END) || (req_tuser == ihs_pkg::REQ_READ);
         s1_in.valid    = p_status.inc_req || s1_in.rsp;
         s1_in.rsp_kind = (req_tuser == ihs_pkg::REQ_READ) ? ihs_pkg::RSP_BIN
                                                           : ihs_pkg::RSP_SUMMARY;
         s1_in.zero     = !idx_in_range;
      end
   end

   // result fields; parser state already holds this request's own finish
   always_comb begin
      sat_now    = p_status.line_sat || bin_sat_ff || (s1_ff.inc && u_status.sat_hit);
      highest_p1 = {1'b0, highest_item} + 1'b1;
      txn_out    = '0;
      used_out   = '0;
      value_out  = '0;
      if (s1_ff.rsp_kind == ihs_pkg::RSP_SUMMARY) begin
         txn_out  = ihs_pkg::OUT_COUNT_BITS'(line_count);
         used_out = p_status.any_item ? ihs_pkg::USED_BITS'(highest_p1) : '0;
      end else if (!s1_ff.zero) begin
         value_out = ihs_pkg::OUT_COUNT_BITS'(cur_value);
      end
      rsp_data_in = '0;
      rsp_data_in[ihs_pkg::RSP_TXN_LSB +: ihs_pkg::OUT_COUNT_BITS]   = txn_out;
      rsp_data_in[ihs_pkg::RSP_USED_LSB +: ihs_pkg::USED_BITS]       = used_out;
      rsp_data_in[ihs_pkg::RSP_VALUE_LSB +: ihs_pkg::OUT_COUNT_BITS] = value_out;
      rsp_data_in[ihs_pkg::RSP_RANGE_BIT] = p_status.range_err;
      rsp_data_in[ihs_pkg::RSP_SAT_BIT]   = sat_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         bin_sat_ff   <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         if (s1_advance && s1_ff.rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_advance && s1_ff.inc && u_status.sat_hit) begin
            bin_sat_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_ff.rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= s1_ff.rsp_kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

@@ rtl/ihs_checker.sv @@
// Port-level checks of the item support histogram, bound to the top level.
module ihs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ihs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                              rsp_tuser
);

   // clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request accepted or result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ihs_pkg::RSP_BIN) |->
         rsp_tdata[ihs_pkg::RSP_VALUE_LSB-1:0] == '0)
      else $error("bin read carries summary fields");

   a_summary_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ihs_pkg::RSP_SUMMARY) |->
         rsp_tdata[ihs_pkg::RSP_RANGE_BIT-1:ihs_pkg::RSP_VALUE_LSB] == '0)
      else $error("summary carries a bin value");

endmodule

bind item_support_histogram_unit ihs_checker u_ihs_checker (.*);

@@ tb/item_support_histogram_unit_tb.sv @@
// Self-checking testbench for the item support histogram unit.
module item_support_histogram_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          BIN_COUNT    = ihs_pkg::NUM_BINS_DEFAULT;
   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam logic [1:0]  REQ_UNUSED   = 2'd3;
   localparam int          RANDOM_ITEMS = 1750;
   localparam int          HOLD_AFTER   = 600;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic        rkind;
      logic [31:0] txn;
      logic [12:0] used;
      logic [31:0] value;
      logic        range_err;
      logic        sat;
   } hist_result_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [7:0]      ch;
      logic [11:0]     idx;
      logic            typed;   // want holds a hand-written result
      hist_result_type want;
   } text_req_type;

   localparam hist_result_type NO_RESULT = '0;

   // opening rows: empty store, pending number at end, oversized item, leading zero
   localparam text_req_type OPENING_ROWS [25] = '{
      '{ihs_pkg::REQ_READ, 8'h00, 12'h000, 1'b1,
        '{ihs_pkg::RSP_BIN, 32'd0, 13'd0, 32'd0, 1'b0, 1'b0}},
      '{ihs_pkg::REQ_END,  8'h00, 12'h000, 1'b1,
        '{ihs_pkg::RSP_SUMMARY, 32'd0, 13'd0, 32'd0, 1'b0, 1'b0}},
      '{REQ_UNUSED,        8'hFF, 12'hFFF, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h30, 12'hFFF, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h0A, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h34, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h30, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h39, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h35, 12'h000, 1'b0, NO_RESULT},
      // unfinished line: 4095 counted, the line is not
      '{ihs_pkg::REQ_END,  8'h00, 12'h000, 1'b1,
        '{ihs_pkg::RSP_SUMMARY, 32'd1, 13'd4096, 32'd0, 1'b0, 1'b0}},
      '{ihs_pkg::REQ_READ, 8'hFF, 12'hFFF, 1'b1,
        '{ihs_pkg::RSP_BIN, 32'd0, 13'd0, 32'd1, 1'b0, 1'b0}},
      '{ihs_pkg::REQ_READ, 8'h00, 12'h000, 1'b1,
        '{ihs_pkg::RSP_BIN, 32'd0, 13'd0, 32'd1, 1'b0, 1'b0}},
      '{ihs_pkg::REQ_TEXT, 8'h39, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h39, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h39, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h39, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h39, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'hFF, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_END,  8'h00, 12'h000, 1'b1,
        '{ihs_pkg::RSP_SUMMARY, 32'd1, 13'd4096, 32'd0, 1'b1, 1'b0}},
      '{ihs_pkg::REQ_TEXT, 8'h30, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h37, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h00, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_READ, 8'h00, 12'h007, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_TEXT, 8'h33, 12'h000, 1'b0, NO_RESULT},
      '{ihs_pkg::REQ_END,  8'h00, 12'h000, 1'b0, NO_RESULT}
   };

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [ihs_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [ihs_pkg::KIND_BITS-1:0]     req_tuser  = ihs_pkg::REQ_TEXT;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [ihs_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tuser;

   item_support_histogram_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted histogram state
   bit [31:0] support_count [BIN_COUNT];
   int        number_acc    = 0;
   bit        digit_seen    = 1'b0;
   bit [31:0] line_count    = '0;
   int        highest_item  = 0;
   bit        any_item      = 1'b0;
   bit        range_error   = 1'b0;
   bit        saturated     = 1'b0;

   text_req_type    request_plan [$];
   hist_result_type pending_results [$];
   int              plan_pos       = 0;
   int              accepted_count = 0;
   int              random_items   = 0;
   int              error_count    = 0;
   int              cycle_count    = 0;

   function automatic void close_number();
      if (digit_seen) begin
         if (number_acc >= BIN_COUNT) begin
            range_error = 1'b1;
         end else begin
            if (support_count[number_acc] == COUNT_MAX) saturated = 1'b1;
            else support_count[number_acc] = support_count[number_acc] + 1;
            if (!any_item || number_acc > highest_item) highest_item = number_acc;
            any_item = 1'b1;
         end
      end
      number_acc = 0;
      digit_seen = 1'b0;
   endfunction

   // advances the predicted state by one request; returns 1 when a result follows
   function automatic bit hist_predict(input text_req_type r, output hist_result_type res);
      bit produced;
      produced = 1'b0;
      res      = NO_RESULT;
      case (r.kind)
         ihs_pkg::REQ_TEXT: begin
            if (r.ch >= ihs_pkg::CH_ZERO && r.ch <= ihs_pkg::CH_NINE) begin
               number_acc = number_acc * ihs_pkg::DIGIT_BASE +
                            (int'(r.ch) - int'(ihs_pkg::CH_ZERO));
               if (number_acc > BIN_COUNT) number_acc = BIN_COUNT;
               digit_seen = 1'b1;
            end else begin
               close_number();
               if (r.ch == ihs_pkg::CH_NEWLINE) begin
                  if (line_count == COUNT_MAX) saturated = 1'b1;
                  else line_count = line_count + 1;
               end
            end
         end
         ihs_pkg::REQ_END: begin
            close_number();
            res.rkind = ihs_pkg::RSP_SUMMARY;
            res.txn   = line_count;
            res.used  = any_item ? 13'(highest_item + 1) : 13'd0;
            produced  = 1'b1;
         end
         ihs_pkg::REQ_READ: begin
            res.rkind = ihs_pkg::RSP_BIN;
            res.value = support_count[r.idx];
            produced  = 1'b1;
         end
         default: produced = 1'b0;
      endcase
      res.range_err = range_error;
      res.sat       = saturated;
      return produced;
   endfunction

   task automatic push_req(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [11:0] idx);
      text_req_type r;
      r.kind  = kind;
      r.ch    = ch;
      r.idx   = idx;
      r.typed = 1'b0;
      r.want  = NO_RESULT;
      request_plan.push_back(r);
      if (kind != REQ_UNUSED) random_items++;
   endtask

   function automatic logic [7:0] pick_separator();
      logic [7:0] sep;
      case ($urandom_range(0, 3))
         0: sep = 8'h20;
         1: sep = 8'h2C;
         2: sep = 8'h09;
         default: begin
            sep = 8'($urandom_range(0, 255));
            if ((sep >= ihs_pkg::CH_ZERO && sep <= ihs_pkg::CH_NINE) ||
                sep == ihs_pkg::CH_NEWLINE) sep = 8'h20;
         end
      endcase
      return sep;
   endfunction

   // mostly well-formed lines of item numbers, mixed with reads, ends and noise
   task automatic build_stimulus();
      int         n_items;
      int         v;
      int         last_v;
      int         sel;
      logic [7:0] digs [$];
      foreach (OPENING_ROWS[i]) request_plan.push_back(OPENING_ROWS[i]);
      last_v = 0;
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            n_items = $urandom_range(1, 6);
            for (int k = 0; k < n_items; k++) begin
               sel = $urandom_range(0, 99);
               if (sel < 20) v = last_v;    // repeated bin, back-to-back updates
               else if (sel < 65) v = $urandom_range(0, 31);
               else if (sel < 88) v = $urandom_range(0, BIN_COUNT - 1);
               else v = $urandom_range(BIN_COUNT, BIN_COUNT + 200000);
               last_v = v;
               if ($urandom_range(0, 9) == 0) begin
                  repeat ($urandom_range(1, 2))
                     push_req(ihs_pkg::REQ_TEXT, ihs_pkg::CH_ZERO,
                              12'($urandom_range(0, 4095)));
               end
               digs.delete();
               do begin
                  digs.push_front(8'(int'(ihs_pkg::CH_ZERO) + v % 10));
                  v = v / 10;
               end while (v > 0);
               foreach (digs[j])
                  push_req(ihs_pkg::REQ_TEXT, digs[j], 12'($urandom_range(0, 4095)));
               if (k < n_items - 1 || $urandom_range(0, 2) == 0)
                  push_req(ihs_pkg::REQ_TEXT, pick_separator(),
                           12'($urandom_range(0, 4095)));
            end
            if ($urandom_range(0, 9) != 0)
               push_req(ihs_pkg::REQ_TEXT, ihs_pkg::CH_NEWLINE,
                        12'($urandom_range(0, 4095)));
         end else if (sel < 80) begin
            push_req(ihs_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 31))
                                                 : 12'($urandom_range(0, 4095)));
         end else if (sel < 88) begin
            push_req(ihs_pkg::REQ_END, 8'($urandom_range(0, 255)),
                     12'($urandom_range(0, 4095)));
         end else if (sel < 95) begin
            repeat ($urandom_range(1, 4))
               push_req(ihs_pkg::REQ_TEXT, 8'($urandom_range(0, 255)),
                        12'($urandom_range(0, 4095)));
         end else begin
            push_req(REQ_UNUSED, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("cycle %0d: %s mismatch, got %0h want %0h", cycle_count, what, got, want);
      error_count++;
   endtask

   // result check, request acceptance and the bursty sender, in one process
   always @(posedge clock) begin : stream_side
      hist_result_type got;
      hist_result_type want;
      hist_result_type predicted;
      text_req_type    on_bus;
      text_req_type    next_req;
      int              burst_left;
      int              gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.rkind     = rsp_tuser;
            got.txn       = rsp_tdata[ihs_pkg::RSP_TXN_LSB +: ihs_pkg::OUT_COUNT_BITS];
            got.used      = rsp_tdata[ihs_pkg::RSP_USED_LSB +: ihs_pkg::USED_BITS];
            got.value     = rsp_tdata[ihs_pkg::RSP_VALUE_LSB +: ihs_pkg::OUT_COUNT_BITS];
            got.range_err = rsp_tdata[ihs_pkg::RSP_RANGE_BIT];
            got.sat       = rsp_tdata[ihs_pkg::RSP_SAT_BIT];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", {31'd0, got.rkind}, 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (got.rkind !== want.rkind)
                  report_mismatch("result_kind", {31'd0, got.rkind}, {31'd0, want.rkind});
               if (got.txn !== want.txn) report_mismatch("transaction_count", got.txn, want.txn);
               if (got.used !== want.used)
                  report_mismatch("bins_used", {19'd0, got.used}, {19'd0, want.used});
               if (got.value !== want.value) report_mismatch("bin_value", got.value, want.value);
               if (got.range_err !== want.range_err)
                  report_mismatch("item_out_of_range", {31'd0, got.range_err},
                                  {31'd0, want.range_err});
               if (got.sat !== want.sat)
                  report_mismatch("count_saturated", {31'd0, got.sat}, {31'd0, want.sat});
            end
         end
         if (req_tvalid && req_tready) begin
            if (hist_predict(on_bus, predicted))
               pending_results.push_back(on_bus.typed ? on_bus.want : predicted);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || plan_pos >= request_plan.size()) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               next_req = request_plan[plan_pos];
               plan_pos++;
               on_bus = next_req;
               req_tvalid <= 1'b1;
               req_tdata  <= {4'd0, next_req.idx, next_req.ch};
               req_tuser  <= next_req.kind;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 16);
                  gap_left   = $urandom_range(0, 6);
               end
            end
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off to back up the pipeline
   always @(posedge clock) begin : sink_side
      int sink_mode;
      int rx_cycle;
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_mode = 0;
         rx_cycle  = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
         rsp_tready <= 1'b0;
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end else begin
         if (rx_cycle % 50 == 0) sink_mode = $urandom_range(0, 3);
         case (sink_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (rx_cycle % 3 != 0);
         endcase
         rx_cycle++;
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // limit covers the clearing pass after reset, the long hold-off and worst-case gaps
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < request_plan.size() || pending_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
